/* hw/rtl/window_median_filter_macros.svh */
// Assertion helpers for the window median filter.
// They sample on clk_i and are held off while rst_ni is low.
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH

`ifndef SYNTH

`define WMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define WMF_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`else

`define WMF_ASSERT(lbl, prop, msg)

`define WMF_ASSERT_NEVER(lbl, prop, msg)

`endif

`endif

/* hw/rtl/wmf_pkg.sv */
package wmf_pkg;

  localparam int RADIUS     = 3;
  localparam int DIAM       = 2 * RADIUS + 1;
  localparam int WIN        = DIAM * DIAM;
  localparam int MID        = WIN / 2;
  localparam int LINES      = DIAM - 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WUSE_W     = $clog2(MAX_WIDTH + 1);
  localparam int HUSE_W     = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W      = 13;
  localparam int CNT_W      = 22;
  localparam int AREA_W     = WUSE_W + HUSE_W;
  localparam int RANK_W     = $clog2(WIN);
  localparam int POP_W      = $clog2(WIN + 1);

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN-1:0]   win_t;

  // state of one word as it walks down the bit-select chain
  typedef struct packed {
    logic              valid;
    logic              interior;
    logic              last;
    pix_t              center;
    logic [WIN-1:0]    mask;
    logic [RANK_W-1:0] rank;
    pix_t              med;
  } sel_t;

endpackage

/* hw/rtl/wmf_line_ram.sv */
module wmf_line_ram (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [wmf_pkg::COL_W-1:0]  rd_addr_i,
  output wmf_pkg::pix_t              rd_data_o,
  input  logic                       wr_en_i,
  input  logic [wmf_pkg::COL_W-1:0]  wr_addr_i,
  input  wmf_pkg::pix_t              wr_data_i
);

  wmf_pkg::pix_t mem_q [wmf_pkg::MAX_WIDTH];
  wmf_pkg::pix_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/wmf_bit_cell.sv */
// Decides one median bit, MSB first: counts candidates with a zero on top,
// keeps the half that holds the wanted rank, and shifts the values left.
module wmf_bit_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  wmf_pkg::sel_t sel_i,
  input  wmf_pkg::win_t vals_i,
  output wmf_pkg::sel_t sel_o,
  output wmf_pkg::win_t vals_o
);

  logic [wmf_pkg::POP_W-1:0] zeros;
  logic                      one;
  wmf_pkg::sel_t             sel_d, sel_q;
  wmf_pkg::win_t             vals_d, vals_q;
  logic                      valid_q;

  always_comb begin
    zeros = '0;
    for (int i = 0; i < wmf_pkg::WIN; i++) begin
      zeros = zeros + wmf_pkg::POP_W'(sel_i.mask[i] & ~vals_i[i][wmf_pkg::PIX_W-1]);
    end
    one = !(wmf_pkg::POP_W'(sel_i.rank) < zeros);
    sel_d = sel_i;
    for (int i = 0; i < wmf_pkg::WIN; i++) begin
      sel_d.mask[i] = sel_i.mask[i] & (vals_i[i][wmf_pkg::PIX_W-1] == one);
      vals_d[i]     = {vals_i[i][wmf_pkg::PIX_W-2:0], 1'b0};
    end
    sel_d.rank = one ? (sel_i.rank - wmf_pkg::RANK_W'(zeros)) : sel_i.rank;
    sel_d.med  = {sel_i.med[wmf_pkg::PIX_W-2:0], one};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= sel_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q  <= sel_d;
      vals_q <= vals_d;
    end
  end

  always_comb begin
    sel_o       = sel_q;
    sel_o.valid = valid_q;
  end

  assign vals_o = vals_q;

endmodule

/* hw/rtl/window_median_filter.sv */
// Channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------
// in       | in_valid_i / in_ready_o    | pixel_in_i
// out      | out_valid_o / out_ready_i  | pixel_out_o, frame_last_o
// cfg      | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One pixel per clock in and out while the output does not stall. A word passes
// the line RAM read at its accepting edge, the window shift, one register per
// bit of the eight-cell median chain and the output register. The line RAMs have
// one read and one write port each, which sets the one-pixel-per-clock rate.
// Reset clears counters and valid bits and loads the default size; no RAM clearing pass.
// A full output register plus skid word stalls input and the whole chain.
`include "window_median_filter_macros.svh"

module window_median_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wmf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wmf_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wmf_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          frame_last_o
);

  localparam int R = wmf_pkg::RADIUS;

  // configuration
  logic [wmf_pkg::WCFG_W-1:0] width_cfg_q;
  logic [wmf_pkg::HCFG_W-1:0] height_cfg_q;
  logic [wmf_pkg::WUSE_W-1:0] width_used;
  logic [wmf_pkg::HUSE_W-1:0] height_used;
  logic [wmf_pkg::AREA_W-1:0] area;
  logic [wmf_pkg::CNT_W-1:0]  last_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= wmf_pkg::WCFG_W'(wmf_pkg::RESET_WIDTH);
      height_cfg_q <= wmf_pkg::HCFG_W'(wmf_pkg::RESET_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wmf_pkg::REG_IMAGE_WIDTH:  width_cfg_q  <= cfg_wdata_i[wmf_pkg::WCFG_W-1:0];
        wmf_pkg::REG_IMAGE_HEIGHT: height_cfg_q <= cfg_wdata_i[wmf_pkg::HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(width_cfg_q) < 32'(wmf_pkg::DIAM)) begin
      width_used = wmf_pkg::WUSE_W'(wmf_pkg::DIAM);
    end else if (32'(width_cfg_q) > 32'(wmf_pkg::MAX_WIDTH)) begin
      width_used = wmf_pkg::WUSE_W'(wmf_pkg::MAX_WIDTH);
    end else begin
      width_used = wmf_pkg::WUSE_W'(width_cfg_q);
    end
    if (32'(height_cfg_q) < 32'(wmf_pkg::DIAM)) begin
      height_used = wmf_pkg::HUSE_W'(wmf_pkg::DIAM);
    end else if (32'(height_cfg_q) > 32'(wmf_pkg::MAX_HEIGHT)) begin
      height_used = wmf_pkg::HUSE_W'(wmf_pkg::MAX_HEIGHT);
    end else begin
      height_used = wmf_pkg::HUSE_W'(height_cfg_q);
    end
  end

  assign area = wmf_pkg::AREA_W'(width_used) * wmf_pkg::AREA_W'(height_used);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= wmf_pkg::CNT_W'(wmf_pkg::RESET_WIDTH * wmf_pkg::RESET_HEIGHT - 1);
    end else begin
      last_idx_q <= wmf_pkg::CNT_W'(area - wmf_pkg::AREA_W'(1));
    end
  end

  // position tracking
  logic                      en, acc;
  logic [wmf_pkg::COL_W-1:0] in_col_q, out_col_q;
  logic [wmf_pkg::ROW_W-1:0] in_row_q, out_row_q;
  logic [wmf_pkg::CNT_W-1:0] out_cnt_q;
  logic                      emit, interior, last, in_wrap, out_wrap;

  assign acc = in_valid_i && in_ready_o;

  assign emit = (in_row_q > wmf_pkg::ROW_W'(R)) ||
                ((in_row_q == wmf_pkg::ROW_W'(R)) && (in_col_q >= wmf_pkg::COL_W'(R)));
  assign interior = (out_row_q >= wmf_pkg::ROW_W'(R)) &&
                    (wmf_pkg::HUSE_W'(out_row_q) + wmf_pkg::HUSE_W'(R) < height_used) &&
                    (out_col_q >= wmf_pkg::COL_W'(R)) &&
                    (wmf_pkg::WUSE_W'(out_col_q) + wmf_pkg::WUSE_W'(R) < width_used);
  assign last     = (out_cnt_q == last_idx_q);
  assign in_wrap  = (wmf_pkg::WUSE_W'(in_col_q) + wmf_pkg::WUSE_W'(1) >= width_used);
  assign out_wrap = (wmf_pkg::WUSE_W'(out_col_q) + wmf_pkg::WUSE_W'(1) >= width_used);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_cnt_q <= '0;
    end else if (cfg_we_i || (acc && emit && last)) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_cnt_q <= '0;
    end else if (acc) begin
      if (emit) begin
        out_cnt_q <= out_cnt_q + wmf_pkg::CNT_W'(1);
        if (out_wrap) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + wmf_pkg::ROW_W'(1);
        end else begin
          out_col_q <= out_col_q + wmf_pkg::COL_W'(1);
        end
      end
      if (in_wrap) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + wmf_pkg::ROW_W'(1);
      end else begin
        in_col_q <= in_col_q + wmf_pkg::COL_W'(1);
      end
    end
  end

  // stage 1: line RAM read
  logic                      v1_q, emit1_q, interior1_q, last1_q;
  wmf_pkg::pix_t             pix1_q;
  logic [wmf_pkg::COL_W-1:0] col1_q;
  wmf_pkg::pix_t             tap [wmf_pkg::LINES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && acc) begin
      pix1_q      <= pixel_in_i;
      col1_q      <= in_col_q;
      emit1_q     <= emit;
      interior1_q <= interior;
      last1_q     <= last;
    end
  end

  // each line RAM hands its old row down to the next one
  for (genvar k = 0; k < wmf_pkg::LINES; k++) begin : g_line
    wmf_line_ram u_line (
      .clk_i     (clk_i),
      .rd_en_i   (acc),
      .rd_addr_i (in_col_q),
      .rd_data_o (tap[k]),
      .wr_en_i   (v1_q),
      .wr_addr_i (col1_q),
      .wr_data_i ((k == 0) ? pix1_q : tap[(k == 0) ? 0 : k - 1])
    );
  end

  // stage 2: window, column 0 newest, row 0 newest
  wmf_pkg::pix_t win_q [wmf_pkg::DIAM][wmf_pkg::DIAM];
  logic          v2_q, interior2_q, last2_q;

  always_ff @(posedge clk_i) begin
    if (en && v1_q) begin
      for (int c = 1; c < wmf_pkg::DIAM; c++) begin
        win_q[c] <= win_q[c-1];
      end
      win_q[0][0] <= pix1_q;
      for (int r = 1; r < wmf_pkg::DIAM; r++) begin
        win_q[0][r] <= tap[r-1];
      end
      interior2_q <= interior1_q;
      last2_q     <= last1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q && emit1_q;
    end
  end

  // median chain
  wmf_pkg::sel_t sel  [wmf_pkg::PIX_W+1];
  wmf_pkg::win_t vals [wmf_pkg::PIX_W+1];

  always_comb begin
    sel[0].valid    = v2_q;
    sel[0].interior = interior2_q;
    sel[0].last     = last2_q;
    sel[0].center   = win_q[R][R];
    sel[0].mask     = '1;
    sel[0].rank     = wmf_pkg::RANK_W'(wmf_pkg::MID);
    sel[0].med      = '0;
    for (int c = 0; c < wmf_pkg::DIAM; c++) begin
      for (int r = 0; r < wmf_pkg::DIAM; r++) begin
        vals[0][c*wmf_pkg::DIAM+r] = win_q[c][r];
      end
    end
  end

  for (genvar b = 0; b < wmf_pkg::PIX_W; b++) begin : g_cell
    wmf_bit_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sel_i  (sel[b]),
      .vals_i (vals[b]),
      .sel_o  (sel[b+1]),
      .vals_o (vals[b+1])
    );
  end

  // output register with skid word
  wmf_pkg::sel_t fin;
  wmf_pkg::pix_t fin_pix;
  logic          out_v_q, out_last_q, skid_v_q, skid_last_q;
  wmf_pkg::pix_t out_pix_q, skid_pix_q;

  assign fin     = sel[wmf_pkg::PIX_W];
  assign fin_pix = fin.interior ? fin.med : fin.center;
  assign en      = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && out_ready_i) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= fin.valid;
      end
    end else if (out_v_q) begin
      if (fin.valid && en) begin
        skid_v_q <= 1'b1;
      end
    end else begin
      out_v_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && out_ready_i && skid_v_q) begin
      out_pix_q  <= skid_pix_q;
      out_last_q <= skid_last_q;
    end else if ((!out_v_q || out_ready_i) && en) begin
      out_pix_q  <= fin_pix;
      out_last_q <= fin.last;
    end
    if (out_v_q && !out_ready_i && en) begin
      skid_pix_q  <= fin_pix;
      skid_last_q <= fin.last;
    end
  end

  assign in_ready_o   = en;
  assign out_valid_o  = out_v_q;
  assign pixel_out_o  = out_pix_q;
  assign frame_last_o = out_last_q;

  `WMF_ASSERT_NEVER(a_skid_alone, skid_v_q && !out_v_q, "skid word without output word")
  `WMF_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i), "skid filled while output drained")
  `WMF_ASSERT(a_col_range, wmf_pkg::WUSE_W'(in_col_q) < width_used, "input column beyond row width")

endmodule

/* dv/window_median_filter_tb.sv */
module window_median_filter_tb;

  localparam int STALL_LIMIT = 5000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [wmf_pkg::CFG_W-1:0]     cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [wmf_pkg::PIX_W-1:0]     pixel_in_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [wmf_pkg::PIX_W-1:0]     pixel_out_o;
  logic                          frame_last_o;

  window_median_filter dut (.*);

  typedef struct packed {
    wmf_pkg::pix_t pix;
    logic          last;
  } filt_word_t;

  filt_word_t filt_q[$];
  int         n_errors;
  bit         idle_on;
  int         rx_hold;

  // predictor state
  wmf_pkg::pix_t lines[wmf_pkg::DIAM*wmf_pkg::MAX_WIDTH];
  int            width_reg, height_reg;
  int            row_in, col_in, out_idx, row_out, col_out;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int eff_width();
    return width_reg < wmf_pkg::DIAM ? wmf_pkg::DIAM :
           (width_reg > wmf_pkg::MAX_WIDTH ? wmf_pkg::MAX_WIDTH : width_reg);
  endfunction

  function automatic int eff_height();
    return height_reg < wmf_pkg::DIAM ? wmf_pkg::DIAM :
           (height_reg > wmf_pkg::MAX_HEIGHT ? wmf_pkg::MAX_HEIGHT : height_reg);
  endfunction

  function automatic wmf_pkg::pix_t line_pix(int r, int c);
    return lines[(r % wmf_pkg::DIAM) * wmf_pkg::MAX_WIDTH + c];
  endfunction

  function automatic wmf_pkg::pix_t median_at(int r, int c);
    wmf_pkg::pix_t w[wmf_pkg::WIN];
    wmf_pkg::pix_t v;
    int            n, k;
    n = 0;
    for (int i = 0; i < wmf_pkg::DIAM; i++)
      for (int j = 0; j < wmf_pkg::DIAM; j++) begin
        w[n] = line_pix(r - wmf_pkg::RADIUS + i, c - wmf_pkg::RADIUS + j);
        n++;
      end
    for (int i = 1; i < wmf_pkg::WIN; i++) begin
      v = w[i];
      k = i - 1;
      while (k >= 0 && w[k] > v) begin
        w[k+1] = w[k];
        k--;
      end
      w[k+1] = v;
    end
    return w[wmf_pkg::MID];
  endfunction

  function automatic void restart_counts();
    row_in = 0; col_in = 0; out_idx = 0; row_out = 0; col_out = 0;
  endfunction

  // advance the filter model by one accepted input word
  function automatic void predict_pixel(wmf_pkg::pix_t p);
    int         w, h;
    filt_word_t e;
    w = eff_width();
    h = eff_height();
    if (row_in < h && col_in < w)
      lines[(row_in % wmf_pkg::DIAM) * wmf_pkg::MAX_WIDTH + col_in] = p;
    if (row_in * w + col_in >= wmf_pkg::RADIUS * w + wmf_pkg::RADIUS) begin
      e.last = (out_idx == w * h - 1);
      if (row_out >= wmf_pkg::RADIUS && row_out + wmf_pkg::RADIUS < h &&
          col_out >= wmf_pkg::RADIUS && col_out + wmf_pkg::RADIUS < w)
        e.pix = median_at(row_out, col_out);
      else
        e.pix = line_pix(row_out, col_out);
      filt_q.insert(filt_q.size(), e);
      if (e.last) begin
        restart_counts();
        return;
      end
      out_idx = (out_idx + 1) & 32'h3FFFFF;
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in = (row_in + 1) & 32'h1FFF;
    end
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready_i <= !(idle_on && $urandom_range(99) < 19);
    end
  end

  always @(posedge clk_i) begin
    filt_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filt_q.size() == 0) begin
        $error("unexpected word: pixel_out=%0d frame_last=%0b", pixel_out_o, frame_last_o);
        n_errors++;
      end else begin
        e = filt_q.pop_front();
        if (pixel_out_o !== e.pix) begin
          $error("pixel_out: expected %0d, got %0d", e.pix, pixel_out_o);
          n_errors++;
        end
        if (frame_last_o !== e.last) begin
          $error("frame_last: expected %0b, got %0b", e.last, frame_last_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles without any handshake while work is outstanding
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (!in_valid_i && filt_q.size() == 0))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_pixel(wmf_pkg::pix_t p);
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixel(p);
  endtask

  task automatic sender_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    sender_quiet();
    while (filt_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [wmf_pkg::CFG_IDX_W-1:0] idx, int val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[wmf_pkg::CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == wmf_pkg::REG_IMAGE_WIDTH) width_reg = val & 32'h7FF;
    else height_reg = val & 32'h1FFF;
    restart_counts();
  endtask

  function automatic wmf_pkg::pix_t gen_pixel(int mode);
    case (mode)
      0:       return wmf_pkg::pix_t'($urandom_range(255));
      1:       return wmf_pkg::pix_t'($urandom_range(3) * 85);
      default: return wmf_pkg::pix_t'($urandom_range(130, 120));
    endcase
  endfunction

  task automatic send_frame(int w, int h, bit pads, int mode);
    for (int i = 0; i < w * h; i++) send_pixel(gen_pixel(mode));
    if (pads)
      for (int i = 0; i < wmf_pkg::RADIUS * w + wmf_pkg::RADIUS; i++)
        send_pixel(wmf_pkg::pix_t'($urandom_range(255)));
  endtask

  task automatic test_directed();
    int w;
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, 7);
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, 7);
    w = eff_width();
    // corner values, a checkerboard of extremes and a bright center
    for (int i = 0; i < 49; i++) begin
      if (i == 0)       send_pixel(8'h00);
      else if (i == 48) send_pixel(8'hFF);
      else if (i == 24) send_pixel(8'hFF);
      else              send_pixel(((i / 7 + i % 7) % 2) ? 8'hFF : 8'h00);
    end
    for (int i = 0; i < wmf_pkg::RADIUS * w + wmf_pkg::RADIUS; i++) send_pixel(8'hA5);
  endtask

  task automatic test_clamped_sizes();
    idle_on = 1'b0;
    // width and height below range
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, 0);
    send_frame(eff_width(), eff_height(), 1'b1, 1);
    // width masked down to 7, height above range; cut short by a restart
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, 13'h1807);
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 40; i++) send_pixel(gen_pixel(0));
    idle_on = 1'b1;
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, 7);
  endtask

  task automatic test_missing_pads();
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, 9);
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, 8);
    send_frame(9, 8, 1'b0, 0);
    send_frame(9, 8, 1'b1, 1);
  endtask

  task automatic test_restart();
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, 11);
    for (int i = 0; i < 60; i++) send_pixel(wmf_pkg::pix_t'($urandom_range(255)));
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, 9);
    send_frame(11, 9, 1'b1, 0);
  endtask

  task automatic test_backpressure();
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, 12);
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, 10);
    rx_hold = 400;
    send_frame(12, 10, 1'b1, 0);
    wait_drained();
  endtask

  task automatic test_random();
    int w, h;
    w = $urandom_range(12, 7);
    h = $urandom_range(9, 7);
    write_reg(wmf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(wmf_pkg::REG_IMAGE_HEIGHT, h);
    send_frame(w, h, $urandom_range(9) != 0, $urandom_range(2));
    send_frame(w, h, 1'b1, $urandom_range(2));
  endtask

  initial begin
    n_errors    = 0;
    idle_on     = 1'b1;
    rx_hold     = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = wmf_pkg::REG_IMAGE_WIDTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pixel_in_i  = '0;
    width_reg   = wmf_pkg::RESET_WIDTH;
    height_reg  = wmf_pkg::RESET_HEIGHT;
    restart_counts();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_missing_pads();
    test_restart();
    test_backpressure();
    test_random();
    test_clamped_sizes();
    wait_drained();
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
